// ===== sv/mhd_pkg.sv =====
// Shared types, constants and helpers for the nearest-codeword decoder.
// No dependencies; the cell and the top level refer to it by scoped names.
package mhd_pkg;

  // Fixed widths of the beat fields.
  localparam int ENTRY_INDEX_W = 8;
  localparam int WORD_W        = 15;
  localparam int SYMBOL_W      = 8;
  localparam int DIST_W        = 4;
  localparam int DIST_MAX      = 15;

  // Defaults for the top-level parameters.
  localparam int SYMBOL_BITS_DEF = 8;
  localparam int WORD_BITS_DEF   = 15;

  // Operation codes carried in the op field.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // Control part of a beat moving along the chain.
  typedef struct packed {
    logic valid;
    logic op;
    logic found;
  } ctl_t;

  // Count the ones of a word of up to 32 bits.
  function automatic logic [5:0] popcount32(input logic [31:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      n = n + 6'(v[i]);
    end
    return n;
  endfunction

endpackage

// ===== sv/mhd_cell.sv =====
// One cell of the decoder chain: holds one codebook entry, compares the
// passing beat against it and hands the beat on. Depends on mhd_pkg.
module mhd_cell #(
  parameter int SYMBOL_BITS = mhd_pkg::SYMBOL_BITS_DEF,
  parameter int WORD_BITS   = mhd_pkg::WORD_BITS_DEF,
  parameter int CELL_INDEX  = 0,
  localparam int DistW      = $clog2(WORD_BITS + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  mhd_pkg::ctl_t          ctl_i,
  input  logic [SYMBOL_BITS-1:0] idx_i,
  input  logic [WORD_BITS-1:0]   word_i,
  input  logic [DistW-1:0]       best_i,
  input  logic [SYMBOL_BITS-1:0] pick_i,
  output mhd_pkg::ctl_t          ctl_o,
  output logic [SYMBOL_BITS-1:0] idx_o,
  output logic [WORD_BITS-1:0]   word_o,
  output logic [DistW-1:0]       best_o,
  output logic [SYMBOL_BITS-1:0] pick_o
);

  logic [WORD_BITS-1:0]   entry_r;
  mhd_pkg::ctl_t          ctl_r, ctl_nxt;
  logic [SYMBOL_BITS-1:0] idx_r;
  logic [WORD_BITS-1:0]   word_r;
  logic [DistW-1:0]       best_r, best_nxt;
  logic [SYMBOL_BITS-1:0] pick_r, pick_nxt;
  logic [DistW-1:0]       cand_dist;
  logic                   hit_load;
  logic                   better;

  assign cand_dist = DistW'(mhd_pkg::popcount32(32'(word_i ^ entry_r)));
  assign hit_load  = en && ctl_i.valid && (ctl_i.op == mhd_pkg::OP_LOAD) &&
                     (idx_i == SYMBOL_BITS'(CELL_INDEX));
  assign better    = (ctl_i.op == mhd_pkg::OP_DECODE) && (cand_dist < best_i);

  always_comb begin
    ctl_nxt  = ctl_i;
    best_nxt = best_i;
    pick_nxt = pick_i;
    if (better) begin
      ctl_nxt.found = 1'b1;
      best_nxt      = cand_dist;
      pick_nxt      = SYMBOL_BITS'(CELL_INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r  <= idx_i;
      word_r <= word_i;
      best_r <= best_nxt;
      pick_r <= pick_nxt;
    end
    if (hit_load) begin
      entry_r <= word_i;
    end
  end

  assign ctl_o  = ctl_r;
  assign idx_o  = idx_r;
  assign word_o = word_r;
  assign best_o = best_r;
  assign pick_o = pick_r;

endmodule

// ===== sv/min_hamming_codebook_decoder_core.sv =====
// Nearest-codeword decoder core: a chain of 2**SYMBOL_BITS cells, one per entry.
// A decode beat is registered in every cell in turn, then in the output buffer, before out_valid.
// Throughput: one beat (load or decode) per cycle; the chain stalls only when
// the two-slot output buffer is full and out_ready is low.
// Reset (rst_n, synchronous): clears all beat valid bits and the output buffer;
// codebook entries are not cleared and are undefined until loaded.
module min_hamming_codebook_decoder_core #(
  parameter int SYMBOL_BITS = mhd_pkg::SYMBOL_BITS_DEF,
  parameter int WORD_BITS   = mhd_pkg::WORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_op,
  input  logic [mhd_pkg::ENTRY_INDEX_W-1:0]  in_entry_index,
  input  logic [mhd_pkg::WORD_W-1:0]         in_word,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mhd_pkg::SYMBOL_W-1:0]       out_symbol,
  output logic                               out_end_marker,
  output logic [mhd_pkg::DIST_W-1:0]         out_distance
);

  localparam int NumCells = 2 ** SYMBOL_BITS;
  localparam int DistW    = $clog2(WORD_BITS + 1);
  // Widths used to extend or trim between fixed port fields and parameters.
  localparam int IdxExtW  = (SYMBOL_BITS > mhd_pkg::ENTRY_INDEX_W) ?
                            SYMBOL_BITS : mhd_pkg::ENTRY_INDEX_W;
  localparam int WordExtW = (WORD_BITS > mhd_pkg::WORD_W) ? WORD_BITS : mhd_pkg::WORD_W;
  localparam int SymExtW  = (SYMBOL_BITS > mhd_pkg::SYMBOL_W) ? SYMBOL_BITS : mhd_pkg::SYMBOL_W;
  localparam int DistExtW = (DistW > mhd_pkg::DIST_W) ? DistW : mhd_pkg::DIST_W;

  // Chain links: link k feeds cell k, link NumCells is the chain's output.
  mhd_pkg::ctl_t          link_ctl  [NumCells+1];
  logic [SYMBOL_BITS-1:0] link_idx  [NumCells+1];
  logic [WORD_BITS-1:0]   link_word [NumCells+1];
  logic [DistW-1:0]       link_best [NumCells+1];
  logic [SYMBOL_BITS-1:0] link_pick [NumCells+1];

  logic                   en;
  logic [IdxExtW-1:0]     idx_ext;
  logic [WordExtW-1:0]    word_ext;
  logic [SymExtW-1:0]     pick_ext;
  logic [DistExtW-1:0]    best_ext;

  // Two-slot output buffer; slot 0 is the head shown on the out_ ports.
  logic [1:0]                     count_r, count_nxt;
  logic [mhd_pkg::SYMBOL_W-1:0]   sym_r   [2];
  logic                           endm_r  [2];
  logic [mhd_pkg::DIST_W-1:0]     dist_r  [2];
  logic [mhd_pkg::SYMBOL_W-1:0]   res_sym;
  logic                           res_end;
  logic [mhd_pkg::DIST_W-1:0]     res_dist;
  logic                           push;
  logic                           pop;

  // Advance the whole chain unless the buffer is full and nothing drains.
  assign en       = (count_r != 2'd2) || out_ready;
  assign in_ready = en;

  // Reduce the index modulo the codebook size, drop word bits above WORD_BITS.
  assign idx_ext  = IdxExtW'(in_entry_index);
  assign word_ext = WordExtW'(in_word);

  // Head of the chain: the zero word is the first candidate, so seed the
  // running best with the weight of the received word.
  assign link_ctl[0]  = '{valid: in_valid && en, op: in_op, found: 1'b0};
  assign link_idx[0]  = idx_ext[SYMBOL_BITS-1:0];
  assign link_word[0] = word_ext[WORD_BITS-1:0];
  assign link_best[0] = DistW'(mhd_pkg::popcount32(32'(word_ext[WORD_BITS-1:0])));
  assign link_pick[0] = '0;

  // One cell per codebook entry, in ascending index order; strict compare in
  // each cell keeps the first entry at the minimum distance.
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    mhd_cell #(
      .SYMBOL_BITS (SYMBOL_BITS),
      .WORD_BITS   (WORD_BITS),
      .CELL_INDEX  (k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_i  (link_ctl[k]),
      .idx_i  (link_idx[k]),
      .word_i (link_word[k]),
      .best_i (link_best[k]),
      .pick_i (link_pick[k]),
      .ctl_o  (link_ctl[k+1]),
      .idx_o  (link_idx[k+1]),
      .word_o (link_word[k+1]),
      .best_o (link_best[k+1]),
      .pick_o (link_pick[k+1])
    );
  end

  // Tail of the chain: load beats are dropped here, decode beats become results.
  assign pick_ext = SymExtW'(link_pick[NumCells]);
  assign best_ext = DistExtW'(link_best[NumCells]);
  assign res_end  = !link_ctl[NumCells].found;
  assign res_sym  = res_end ? '0 : pick_ext[mhd_pkg::SYMBOL_W-1:0];
  // Saturate the distance to the width of the result field.
  assign res_dist = (best_ext > DistExtW'(mhd_pkg::DIST_MAX)) ?
                    mhd_pkg::DIST_W'(mhd_pkg::DIST_MAX) : best_ext[mhd_pkg::DIST_W-1:0];

  assign push = en && link_ctl[NumCells].valid && (link_ctl[NumCells].op == mhd_pkg::OP_DECODE);
  assign pop  = out_valid && out_ready;

  always_comb begin
    count_nxt = count_r;
    case (count_r)
      2'd0: begin
        if (push) count_nxt = 2'd1;
      end
      2'd1: begin
        if (push && !pop) count_nxt = 2'd2;
        else if (!push && pop) count_nxt = 2'd0;
      end
      2'd2: begin
        if (pop && !push) count_nxt = 2'd1;
      end
      default: count_nxt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Buffer payload: refill the head on pop, park a new result behind it.
  always_ff @(posedge clk) begin
    case (count_r)
      2'd0: begin
        if (push) begin
          sym_r[0] <= res_sym; endm_r[0] <= res_end; dist_r[0] <= res_dist;
        end
      end
      2'd1: begin
        if (push && pop) begin
          sym_r[0] <= res_sym; endm_r[0] <= res_end; dist_r[0] <= res_dist;
        end else if (push) begin
          sym_r[1] <= res_sym; endm_r[1] <= res_end; dist_r[1] <= res_dist;
        end
      end
      2'd2: begin
        if (pop) begin
          sym_r[0] <= sym_r[1]; endm_r[0] <= endm_r[1]; dist_r[0] <= dist_r[1];
        end
        if (push) begin
          sym_r[1] <= res_sym; endm_r[1] <= res_end; dist_r[1] <= res_dist;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid      = (count_r != 2'd0);
  assign out_symbol     = sym_r[0];
  assign out_end_marker = endm_r[0];
  assign out_distance   = dist_r[0];

  // An end-of-data result never names a symbol.
  a_end_zero_symbol: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_marker |-> out_symbol == '0)
    else $error("end marker with nonzero symbol");

  // The chain only stalls behind a full buffer.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (count_r == 2'd2) && out_valid)
    else $error("input stalled without a full output buffer");

  // After a decode beat leaves the chain, the output is valid in the next cycle.
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid)
    else $error("result lost at chain tail");

  // Buffer occupancy never exceeds two slots.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("output buffer overflow");

endmodule
